FILE: rtl/ile_pkg.sv
// Package for the indexed list engine: sizes, action and status codes,
// and the controller state type. No dependencies.
`default_nettype none
package ile_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int DATA_W   = 32;

	typedef enum logic [2:0] {
		ACT_INSERT      = 3'd0,
		ACT_APPEND      = 3'd1,
		ACT_REMOVE      = 3'd2,
		ACT_REMOVE_BACK = 3'd3,
		ACT_READ        = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_PUT,
		S_GET,
		S_DEL,
		S_RDATA,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/ile_if.sv
// Request and response channel interfaces of the indexed list engine.
// Depends on ile_pkg for the field widths.
`default_nettype none
interface ile_req_if;
	logic                              valid;
	logic                              ready;
	logic [2:0]                        action;
	logic [ile_pkg::CNT_W-1:0]         position;
	logic signed [ile_pkg::DATA_W-1:0] item_value;

	modport source (output valid, action, position, item_value, input ready);
	modport sink (input valid, action, position, item_value, output ready);
endinterface

interface ile_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [ile_pkg::DATA_W-1:0] result_value;
	logic [1:0]                        status;
	logic [ile_pkg::CNT_W-1:0]         length;

	modport source (output valid, result_value, status, length, input ready);
	modport sink (input valid, result_value, status, length, output ready);
endinterface
`default_nettype wire

FILE: rtl/indexed_list_engine_unit.sv
// Indexed list engine: an ordered list of up to CAPACITY signed values in one
// synchronous RAM with read-modify-write shifting. Depends on ile_pkg, ile_if.
// A rejected request goes straight to the result. Insert at p moves the entries from
// p to the end up by one, starting at the end, then writes the new value; remove at p
// moves the entries above p down by one. One request is in work at a time; the shift
// loop moves one entry per cycle through the single RAM port pair.
// A finished result waits in the output register while the next request runs.
// Reset clears the length, the controller and the output valid; the RAM holds
// no reset value.
`default_nettype none
module indexed_list_engine_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ile_req_if.sink    req,
	ile_rsp_if.source  rsp
);

	localparam int AW = ile_pkg::ADDR_W;
	localparam int CW = ile_pkg::CNT_W;
	localparam int DW = ile_pkg::DATA_W;

	ile_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] ptr_q;
	logic [DW-1:0] val_q;
	logic          is_read_q;
	logic          pend_q;
	logic [AW-1:0] pend_addr_s1;
	logic          got_pend_q;
	logic [DW-1:0] got_q;
	logic [DW-1:0] res_val_q;
	ile_pkg::status_t res_st_q;

	logic          out_valid_q;
	logic [DW-1:0] out_val_q;
	logic [1:0]    out_st_q;
	logic [CW-1:0] out_len_q;

	// RAM
	logic [DW-1:0] mem [ile_pkg::CAPACITY];
	logic [DW-1:0] mem_rd_s1;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [DW-1:0] mem_wdata;

	// Request decode
	logic             dec_fail;
	logic             dec_ins;
	logic             dec_read;
	logic [CW-1:0]    dec_pos;
	ile_pkg::status_t dec_st;

	logic accept;
	logic out_load;
	logic count_full;

	assign count_full = (count_q == CW'(ile_pkg::CAPACITY));
	assign accept     = req.valid && req.ready;
	assign out_load   = (state_q == ile_pkg::S_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		dec_fail = 1'b0;
		dec_ins  = 1'b0;
		dec_read = 1'b0;
		dec_pos  = req.position;
		dec_st   = ile_pkg::ST_RANGE;
		case (req.action)
			ile_pkg::ACT_INSERT: begin
				dec_ins = 1'b1;
				if (count_full) begin
					dec_fail = 1'b1;
					dec_st   = ile_pkg::ST_FULL;
				end else if (req.position > count_q) begin
					dec_fail = 1'b1;
				end
			end
			ile_pkg::ACT_APPEND: begin
				dec_ins = 1'b1;
				dec_pos = count_q;
				if (count_full) begin
					dec_fail = 1'b1;
					dec_st   = ile_pkg::ST_FULL;
				end
			end
			ile_pkg::ACT_REMOVE: begin
				dec_fail = (req.position >= count_q);
			end
			ile_pkg::ACT_REMOVE_BACK: begin
				dec_pos  = count_q - CW'(1);
				dec_fail = (count_q == '0);
			end
			ile_pkg::ACT_READ: begin
				dec_read = 1'b1;
				dec_fail = (req.position >= count_q);
			end
			default: begin
				dec_fail = 1'b1;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ile_pkg::S_IDLE: begin
				if (req.valid) begin
					if (dec_fail)
						state_d = ile_pkg::S_DONE;
					else if (dec_ins)
						state_d = ile_pkg::S_INS;
					else
						state_d = ile_pkg::S_GET;
				end
			end
			ile_pkg::S_INS: begin
				if (ptr_q <= pos_q)
					state_d = ile_pkg::S_PUT;
			end
			ile_pkg::S_PUT:   state_d = ile_pkg::S_DONE;
			ile_pkg::S_GET:   state_d = is_read_q ? ile_pkg::S_RDATA : ile_pkg::S_DEL;
			ile_pkg::S_DEL: begin
				if (ptr_q >= count_q)
					state_d = ile_pkg::S_DONE;
			end
			ile_pkg::S_RDATA: state_d = ile_pkg::S_DONE;
			ile_pkg::S_DONE: begin
				if (out_load)
					state_d = ile_pkg::S_IDLE;
			end
			default:          state_d = ile_pkg::S_IDLE;
		endcase
	end

	// Outputs of the controller: handshake and RAM port controls
	always_comb begin
		req.ready = (state_q == ile_pkg::S_IDLE);
		mem_we    = 1'b0;
		mem_waddr = pend_addr_s1;
		mem_wdata = mem_rd_s1;
		mem_raddr = '0;
		case (state_q)
			ile_pkg::S_INS: begin
				mem_we = pend_q;
				if (ptr_q > pos_q)
					mem_raddr = AW'(ptr_q - CW'(1));
			end
			ile_pkg::S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = val_q;
			end
			ile_pkg::S_GET: begin
				mem_raddr = pos_q[AW-1:0];
			end
			ile_pkg::S_DEL: begin
				mem_we = pend_q;
				if (ptr_q < count_q)
					mem_raddr = ptr_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		mem_rd_s1 <= mem[mem_raddr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ile_pkg::S_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			got_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ile_pkg::S_INS: begin
					pend_q <= (ptr_q > pos_q);
				end
				ile_pkg::S_PUT: begin
					pend_q  <= 1'b0;
					count_q <= count_q + CW'(1);
				end
				ile_pkg::S_GET: begin
					got_pend_q <= 1'b1;
				end
				ile_pkg::S_DEL: begin
					got_pend_q <= 1'b0;
					pend_q     <= (ptr_q < count_q);
					if (ptr_q >= count_q)
						count_q <= count_q - CW'(1);
				end
				ile_pkg::S_RDATA: begin
					got_pend_q <= 1'b0;
				end
				default: begin
				end
			endcase
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ile_pkg::S_IDLE: begin
				if (accept) begin
					pos_q     <= dec_pos;
					val_q     <= req.item_value;
					is_read_q <= dec_read;
					ptr_q     <= count_q;
					res_val_q <= '1;
					res_st_q  <= dec_st;
				end
			end
			ile_pkg::S_INS: begin
				// Entry ptr-1 is read now and lands at ptr next cycle.
				if (ptr_q > pos_q) begin
					pend_addr_s1 <= ptr_q[AW-1:0];
					ptr_q        <= ptr_q - CW'(1);
				end
			end
			ile_pkg::S_PUT: begin
				res_val_q <= '0;
				res_st_q  <= ile_pkg::ST_OK;
			end
			ile_pkg::S_GET: begin
				ptr_q <= pos_q + CW'(1);
			end
			ile_pkg::S_DEL: begin
				// The first word returned is the removed entry itself.
				if (got_pend_q)
					got_q <= mem_rd_s1;
				if (ptr_q < count_q) begin
					pend_addr_s1 <= AW'(ptr_q - CW'(1));
					ptr_q        <= ptr_q + CW'(1);
				end else begin
					res_val_q <= got_pend_q ? mem_rd_s1 : got_q;
					res_st_q  <= ile_pkg::ST_OK;
				end
			end
			ile_pkg::S_RDATA: begin
				res_val_q <= mem_rd_s1;
				res_st_q  <= ile_pkg::ST_OK;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_val_q <= res_val_q;
			out_st_q  <= res_st_q;
			out_len_q <= count_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_val_q;
	assign rsp.status       = out_st_q;
	assign rsp.length       = out_len_q;

endmodule
`default_nettype wire

FILE: rtl/ile_checker.sv
// Port-level checker for the indexed list engine and its bind to the top level.
// Depends on ile_pkg.
`default_nettype none
module ile_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] rsp_result_value,
	input wire logic [1:0]  rsp_status,
	input wire logic [6:0]  rsp_length
);

	localparam logic [6:0] CAP = 7'(ile_pkg::CAPACITY);

	// A pending result transaction is held until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ile_pkg::ST_OK |-> rsp_result_value == 32'hFFFF_FFFF)
		else $error("failed transaction without -1 value");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ile_pkg::ST_FULL |-> rsp_length == CAP)
		else $error("full status while list not full");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_length <= CAP && rsp_status != 2'd3)
		else $error("length or status out of range");

endmodule

bind indexed_list_engine_unit ile_checker u_ile_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_result_value (rsp.result_value),
	.rsp_status       (rsp.status),
	.rsp_length       (rsp.length)
);
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for indexed_list_engine_unit: directed list edge cases, a full list,
// random traffic under several idle and stall mixes and a long output stall. Depends on ile_pkg, ile_if.
module tb;
	import ile_pkg::*;

	localparam int                       STALL_LIMIT  = 4000;
	localparam int                       HOLD_CYCLES  = 300;
	localparam int                       DRAIN_CYCLES = CAPACITY + 8;
	localparam logic signed [DATA_W-1:0] FAIL_VALUE   = -1;
	localparam logic [2:0]               ACT_SPARE_LO = 3'd5;
	localparam logic [2:0]               ACT_SPARE_HI = 3'd7;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		status_t                  status;
		logic [CNT_W-1:0]         length;
	} list_result_t;

	logic clk;
	logic arst_n;

	ile_req_if req_ch ();
	ile_rsp_if rsp_ch ();

	indexed_list_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the list, updated when a request is accepted.
	logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
	int unsigned              shadow_count;
	list_result_t             pending_results [$];

	int error_count;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;

	always #1 clk = ~clk;

	task automatic report_failure(input string what);
		error_count++;
		if (error_count <= 10) begin
			$display("%0t: %s", $time, what);
		end
	endtask

	function automatic list_result_t predict_list_op(input logic [2:0] act,
		input logic [CNT_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		list_result_t res;
		int unsigned  p;
		res.value  = FAIL_VALUE;
		res.status = ST_RANGE;
		p = pos;
		case (act)
			ACT_INSERT, ACT_APPEND: begin
				if (shadow_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					if (act == ACT_APPEND) begin
						p = shadow_count;
					end
					if (p <= shadow_count) begin
						for (int i = shadow_count; i > p; i--) begin
							shadow_entries[i] = shadow_entries[i - 1];
						end
						shadow_entries[p] = val;
						shadow_count++;
						res.value  = '0;
						res.status = ST_OK;
					end
				end
			end
			ACT_REMOVE: begin
				if (p < shadow_count) begin
					res.value = shadow_entries[p];
					for (int i = p; i + 1 < shadow_count; i++) begin
						shadow_entries[i] = shadow_entries[i + 1];
					end
					shadow_count--;
					res.status = ST_OK;
				end
			end
			ACT_REMOVE_BACK: begin
				if (shadow_count > 0) begin
					shadow_count--;
					res.value  = shadow_entries[shadow_count];
					res.status = ST_OK;
				end
			end
			ACT_READ: begin
				if (p < shadow_count) begin
					res.value  = shadow_entries[p];
					res.status = ST_OK;
				end
			end
			default: begin
			end
		endcase
		res.length = CNT_W'(shadow_count);
		return res;
	endfunction

	task automatic send_list_op(input logic [2:0] act, input int pos,
		input logic signed [DATA_W-1:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= act;
		req_ch.position   <= CNT_W'(pos);
		req_ch.item_value <= val;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		pending_results.push_back(predict_list_op(act, CNT_W'(pos), val));
	endtask

	task automatic stop_sending();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	task automatic wait_for_results();
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return FAIL_VALUE;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_list();
		send_list_op(ACT_REMOVE_BACK, 0, pick_value());
		send_list_op(ACT_REMOVE, 0, pick_value());
		send_list_op(ACT_READ, 0, pick_value());
		send_list_op(ACT_READ, CAPACITY, pick_value());
		send_list_op(ACT_INSERT, 1, 32'h1234_5678);
		send_list_op(ACT_INSERT, 0, 32'h7fff_ffff);
		send_list_op(ACT_APPEND, CAPACITY, 32'h8000_0000);
		send_list_op(ACT_INSERT, 1, FAIL_VALUE);
		send_list_op(ACT_INSERT, 3, 32'h5555_aaaa);
		send_list_op(ACT_INSERT, 4, 32'h0000_0001);
		send_list_op(ACT_READ, 0, pick_value());
		send_list_op(ACT_READ, 1, pick_value());
		send_list_op(ACT_READ, 2, pick_value());
		send_list_op(ACT_READ, 3, pick_value());
		send_list_op(ACT_READ, 4, pick_value());
		send_list_op(ACT_REMOVE, 4, pick_value());
		send_list_op(ACT_REMOVE, 1, pick_value());
		send_list_op(ACT_SPARE_LO, 0, 32'hdead_beef);
		send_list_op(ACT_SPARE_HI, CAPACITY, pick_value());
		send_list_op(ACT_REMOVE_BACK, 0, pick_value());
		send_list_op(ACT_REMOVE, 0, pick_value());
		send_list_op(ACT_REMOVE_BACK, 0, pick_value());
		send_list_op(ACT_REMOVE_BACK, 0, pick_value());
		stop_sending();
		wait_for_results();
	endtask

	task automatic test_full_list();
		for (int i = 0; i < CAPACITY; i++) begin
			send_list_op(ACT_APPEND, i, pick_value());
		end
		// A full list refuses an insert before the position is looked at.
		send_list_op(ACT_INSERT, CAPACITY, pick_value());
		send_list_op(ACT_INSERT, 0, pick_value());
		send_list_op(ACT_APPEND, 0, pick_value());
		send_list_op(ACT_READ, CAPACITY - 1, pick_value());
		send_list_op(ACT_READ, CAPACITY, pick_value());
		send_list_op(ACT_REMOVE, CAPACITY, pick_value());
		send_list_op(ACT_REMOVE, 0, pick_value());
		send_list_op(ACT_INSERT, 0, 32'h8000_0000);
		send_list_op(ACT_READ, 0, pick_value());
		send_list_op(ACT_REMOVE, CAPACITY - 1, pick_value());
		send_list_op(ACT_INSERT, CAPACITY - 1, 32'h7fff_ffff);
		send_list_op(ACT_READ, CAPACITY - 1, pick_value());
		while (shadow_count > 0) begin
			send_list_op(ACT_REMOVE_BACK, 0, pick_value());
		end
		send_list_op(ACT_REMOVE_BACK, 0, pick_value());
		stop_sending();
		wait_for_results();
	endtask

	task automatic send_random_op(input int grow_pct);
		logic [2:0] act;
		int         pos;
		int         r;
		r = $urandom_range(99);
		if (r < 2) begin
			act = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
		end else if ($urandom_range(99) < grow_pct) begin
			act = $urandom_range(1) ? ACT_INSERT : ACT_APPEND;
		end else begin
			r = $urandom_range(9);
			act = (r < 4) ? ACT_REMOVE : (r < 7) ? ACT_REMOVE_BACK : ACT_READ;
		end
		// Mostly legal positions, with some anywhere from 0 to CAPACITY.
		if ($urandom_range(9) == 0) begin
			pos = $urandom_range(CAPACITY);
		end else if (act == ACT_INSERT || act == ACT_APPEND) begin
			pos = $urandom_range(shadow_count);
		end else if (shadow_count > 0) begin
			pos = $urandom_range(shadow_count - 1);
		end else begin
			pos = $urandom_range(CAPACITY);
		end
		send_list_op(act, pos, pick_value());
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < n; k++) begin
			send_random_op((k % 50 < 30) ? 85 : 15);
		end
		stop_sending();
		wait_for_results();
	endtask

	task automatic test_output_stall();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_request = 1'b1;
		for (int k = 0; k < 16; k++) begin
			send_random_op(60);
		end
		stop_sending();
		wait_for_results();
	endtask

	initial begin : rsp_driver
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_failure($sformatf("unexpected result value=%0d status=%0d length=%0d",
					rsp_ch.result_value, rsp_ch.status, rsp_ch.length));
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.result_value !== want.value || rsp_ch.status !== want.status ||
					rsp_ch.length !== want.length) begin
					report_failure($sformatf(
						"mismatch: value %0d/%0d status %0d/%0d length %0d/%0d (exp/got)",
						want.value, rsp_ch.result_value, want.status, rsp_ch.status,
						want.length, rsp_ch.length));
				end
			end
		end
	end

	// Counts cycles with work outstanding in which no transaction completes.
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(pending_results.size() == 0 && !req_ch.valid)) begin
				stuck = 0;
			end else begin
				stuck++;
			end
		end
		$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.action     = ACT_READ;
		req_ch.position   = '0;
		req_ch.item_value = '0;
		rsp_ch.ready      = 1'b0;
		hold_request      = 1'b0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		error_count       = 0;
		shadow_count      = 0;
		for (int i = 0; i < CAPACITY; i++) begin
			shadow_entries[i] = '0;
		end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_full_list();
		test_random_traffic(0, 0, 60);
		test_random_traffic(81, 0, 60);
		test_random_traffic(0, 81, 60);
		test_random_traffic(34, 34, 60);
		test_output_stall();

		if (pending_results.size() != 0) begin
			report_failure($sformatf("%0d results never arrived", pending_results.size()));
		end
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

FILE: indexed_list_engine_unit.f
rtl/ile_pkg.sv
rtl/ile_if.sv
rtl/indexed_list_engine_unit.sv
rtl/ile_checker.sv
tb/tb.sv
